// ===== src/elfu_pkg.sv =====
// Shared types, codes and constants of the epoch lease fencing unit.
`timescale 1ns / 1ps
package elfu_pkg;

    // Guard hash constants
    localparam logic [63:0] MIX_SEED = 64'hA3E6_19D4_70B2_5C8F;
    localparam logic [63:0] MIX_MUL1 = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL2 = 64'h94D0_49BB_1331_11EB;
    localparam int unsigned MIX_ROT  = 23;
    localparam int unsigned MIX_SH1  = 30;
    localparam int unsigned MIX_SH2  = 27;
    localparam int unsigned MIX_SH3  = 31;

    // Number of registered stages in the guard hash unit
    localparam int unsigned MIX_STAGES = 5;

    // Reset value of the heartbeat timeout register (ns)
    localparam logic [63:0] TIMEOUT_RESET = 64'd1000000000;

    typedef enum logic [2:0] {
        OP_CLAIM = 3'd0,
        OP_BEAT  = 3'd1,
        OP_STOP  = 3'd2,
        OP_PEEK  = 3'd3,
        OP_CLEAR = 3'd4
    } t_opcode;

    typedef enum logic [3:0] {
        RS_INVALID   = 4'd0,
        RS_ACQUIRED  = 4'd1,
        RS_RENEWED   = 4'd2,
        RS_TAKEOVER  = 4'd3,
        RS_SPLIT     = 4'd4,
        RS_OLD_EPOCH = 4'd5,
        RS_CORRUPT   = 4'd6,
        RS_RECORDED  = 4'd7,
        RS_LOST      = 4'd8,
        RS_TIME_BACK = 4'd9
    } t_status;

    typedef enum logic [1:0] {
        HL_EMPTY   = 2'd0,
        HL_LIVE    = 2'd1,
        HL_STALE   = 2'd2,
        HL_CORRUPT = 2'd3
    } t_health;

    // State update applied at commit
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_TAKE,
        ACT_BEAT_NOW,
        ACT_BEAT_ZERO,
        ACT_CLEAR
    } t_act;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WAIT_CHK,
        S_DECIDE,
        S_WAIT_NEW,
        S_COMMIT,
        S_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic hash_start;
        logic hash_sel_new;
        logic decide;
        logic commit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic hash_done;
        logic take;
    } t_sts;

endpackage

// ===== src/elfu_if.sv =====
// Request and response channel interfaces of the lease unit.
`timescale 1ns / 1ps
interface elfu_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [63:0] owner_id;
    logic [63:0] epoch_in;
    logic [63:0] now_time;

    modport source (output valid, opcode, owner_id, epoch_in, now_time, input ready);
    modport sink   (input valid, opcode, owner_id, epoch_in, now_time, output ready);
endinterface

interface elfu_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [1:0]  health;
    logic [63:0] owner_out;
    logic [63:0] epoch_out;
    logic [63:0] heartbeat_out;

    modport source (output valid, status, health, owner_out, epoch_out, heartbeat_out,
                    input ready);
    modport sink   (input valid, status, health, owner_out, epoch_out, heartbeat_out,
                    output ready);
endinterface

// ===== src/epoch_lease_fencing_unit.sv =====
// Top level of the epoch lease fencing unit.
//
// One ownership lease with fencing epochs. Requests arrive on i_req (opcode,
// owner_id, epoch_in, now_time) and each produces exactly one response on
// o_rsp (status, health and the stored owner, epoch and last heartbeat after
// the request). Both channels transfer when valid and ready are high at a
// rising edge. The heartbeat timeout register is written through
// i_cfg_wr_en / i_cfg_wr_data; the user must write it only while the unit
// is idle, as the block itself does not enforce this. One request is
// handled at a time: i_req.ready is low until the previous response has
// transferred. A claim that writes a new lease (acquire or takeover) needs
// a second pass through the five-stage guard hash for the new owner and epoch.
// While the response waits for o_rsp.ready the result is held and i_req.ready
// stays low. Reset (i_rst_n low, synchronous) empties the lease, drops any
// request in flight and loads the timeout with 1000000000 ns.
`timescale 1ns / 1ps
module epoch_lease_fencing_unit
    import elfu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    elfu_req_if.sink    i_req,
    elfu_rsp_if.source  o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;
    logic w_out_valid;

    elfu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    elfu_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_opcode        (i_req.opcode),
        .i_owner_id      (i_req.owner_id),
        .i_epoch_in      (i_req.epoch_in),
        .i_now_time      (i_req.now_time),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_status        (o_rsp.status),
        .o_health        (o_rsp.health),
        .o_owner_out     (o_rsp.owner_out),
        .o_epoch_out     (o_rsp.epoch_out),
        .o_heartbeat_out (o_rsp.heartbeat_out)
    );

    // Drive handshakes
    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;

endmodule

// ===== src/elfu_mix.sv =====
// Five-stage guard hash unit: 64-bit mix of owner and epoch, never zero.
`timescale 1ns / 1ps
module elfu_mix
    import elfu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_owner,
    input  logic [63:0] i_epoch,
    output logic        o_done,
    output logic [63:0] o_guard
);

    logic [MIX_STAGES-1:0] r_stg;
    logic [63:0] r_v0;
    logic [63:0] r_p1_ll;
    logic [31:0] r_p1_lh;
    logic [31:0] r_p1_hl;
    logic [63:0] r_v2;
    logic [63:0] r_p3_ll;
    logic [31:0] r_p3_lh;
    logic [31:0] r_p3_hl;
    logic [63:0] r_guard;

    logic [63:0] w_x;
    logic [63:0] w_m1;
    logic [63:0] w_m2;
    logic [63:0] w_g;

    // Stage valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg <= '0;
        end else begin
            r_stg <= {r_stg[MIX_STAGES-2:0], i_start};
        end
    end

    // Fold owner with rotated epoch and seed
    assign w_x = i_owner ^ ((i_epoch << MIX_ROT) | (i_epoch >> (64 - MIX_ROT))) ^ MIX_SEED;

    // Sum partial products: low 64 bits of the full product
    assign w_m1 = r_p1_ll + {r_p1_lh + r_p1_hl, 32'd0};
    assign w_m2 = r_p3_ll + {r_p3_lh + r_p3_hl, 32'd0};
    assign w_g  = w_m2 ^ (w_m2 >> MIX_SH3);

    // Hash pipeline, one 32x32 product per multiplier per stage
    always_ff @(posedge i_clk) begin
        r_v0    <= w_x ^ (w_x >> MIX_SH1);
        r_p1_ll <= r_v0[31:0] * MIX_MUL1[31:0];
        r_p1_lh <= r_v0[31:0] * MIX_MUL1[63:32];
        r_p1_hl <= r_v0[63:32] * MIX_MUL1[31:0];
        r_v2    <= w_m1 ^ (w_m1 >> MIX_SH2);
        r_p3_ll <= r_v2[31:0] * MIX_MUL2[31:0];
        r_p3_lh <= r_v2[31:0] * MIX_MUL2[63:32];
        r_p3_hl <= r_v2[63:32] * MIX_MUL2[31:0];
        if (r_stg[MIX_STAGES-2]) begin
            r_guard <= (w_g == 64'd0) ? 64'd1 : w_g;
        end
    end

    assign o_done  = r_stg[MIX_STAGES-1];
    assign o_guard = r_guard;

endmodule

// ===== src/elfu_datapath.sv =====
// Lease datapath: item capture, lease registers, guard check and decision logic.
`timescale 1ns / 1ps
module elfu_datapath
    import elfu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    input  logic [2:0]  i_opcode,
    input  logic [63:0] i_owner_id,
    input  logic [63:0] i_epoch_in,
    input  logic [63:0] i_now_time,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic [3:0]  o_status,
    output logic [1:0]  o_health,
    output logic [63:0] o_owner_out,
    output logic [63:0] o_epoch_out,
    output logic [63:0] o_heartbeat_out
);

    logic [63:0] r_timeout;
    logic [63:0] r_lease_epoch;
    logic [63:0] r_lease_owner;
    logic [63:0] r_identity;
    logic [63:0] r_last_beat;

    t_opcode     r_op;
    logic [63:0] r_own;
    logic [63:0] r_ep;
    logic [63:0] r_now;

    t_status     r_status;
    t_health     r_health;
    t_act        r_act;
    t_status     n_status;
    t_health     n_health;
    t_act        n_act;

    logic        w_done;
    logic [63:0] w_guard;
    logic        w_chk_ok;
    logic        w_stale;
    logic        w_match;
    logic        w_zero_arg;
    logic        w_empty;

    // Guard hash of stored pair, or of the request pair for a new lease
    elfu_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.hash_start),
        .i_owner (i_cmd.hash_sel_new ? r_own : r_lease_owner),
        .i_epoch (i_cmd.hash_sel_new ? r_ep : r_lease_epoch),
        .o_done  (w_done),
        .o_guard (w_guard)
    );

    // Timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            r_timeout <= i_cfg_wr_data;
        end
    end

    // Capture the request on transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= t_opcode'(i_opcode);
            r_own <= i_owner_id;
            r_ep  <= i_epoch_in;
            r_now <= i_now_time;
        end
    end

    assign w_chk_ok   = (w_guard == r_identity);
    assign w_stale    = (r_last_beat == 64'd0) || (r_now < r_last_beat) ||
                        ((r_now - r_last_beat) > r_timeout);
    assign w_match    = (r_lease_epoch == r_ep) && (r_lease_owner == r_own);
    assign w_zero_arg = (r_own == 64'd0) || (r_ep == 64'd0) || (r_now == 64'd0);
    assign w_empty    = (r_lease_epoch == 64'd0) && (r_lease_owner == 64'd0) &&
                        (r_last_beat == 64'd0) && (r_identity == 64'd0);

    // Decide status, health and state update
    always_comb begin
        n_status = RS_INVALID;
        n_health = HL_EMPTY;
        n_act    = ACT_NONE;
        unique case (r_op)
            OP_CLAIM: begin
                priority if (w_zero_arg || (r_timeout == 64'd0)) begin
                    n_status = RS_INVALID;
                end else if (r_lease_epoch == 64'd0) begin
                    n_status = RS_ACQUIRED;
                    n_act    = ACT_TAKE;
                end else if ((r_lease_owner == 64'd0) || !w_chk_ok) begin
                    n_status = RS_CORRUPT;
                end else if (r_lease_epoch == r_ep) begin
                    priority if (r_lease_owner != r_own) begin
                        n_status = RS_SPLIT;
                    end else if (r_now < r_last_beat) begin
                        n_status = RS_CORRUPT;
                    end else begin
                        n_status = RS_RENEWED;
                        n_act    = ACT_BEAT_NOW;
                    end
                end else if (!w_stale) begin
                    n_status = RS_SPLIT;
                end else if (r_ep <= r_lease_epoch) begin
                    n_status = RS_OLD_EPOCH;
                end else begin
                    n_status = RS_TAKEOVER;
                    n_act    = ACT_TAKE;
                end
            end
            OP_BEAT: begin
                priority if (w_zero_arg) begin
                    n_status = RS_INVALID;
                end else if (!w_match) begin
                    n_status = RS_LOST;
                end else if (!w_chk_ok) begin
                    n_status = RS_CORRUPT;
                end else if (r_now < r_last_beat) begin
                    n_status = RS_TIME_BACK;
                end else begin
                    n_status = RS_RECORDED;
                    n_act    = ACT_BEAT_NOW;
                end
            end
            OP_STOP: begin
                priority if (!w_match) begin
                    n_status = RS_LOST;
                end else if (!w_chk_ok) begin
                    n_status = RS_CORRUPT;
                end else begin
                    n_status = RS_RECORDED;
                    n_act    = ACT_BEAT_ZERO;
                end
            end
            OP_PEEK: begin
                priority if (w_empty) begin
                    n_health = HL_EMPTY;
                end else if ((r_lease_epoch == 64'd0) || (r_lease_owner == 64'd0) ||
                             !w_chk_ok || (r_now == 64'd0) || (r_timeout == 64'd0)) begin
                    n_health = HL_CORRUPT;
                end else if (w_stale) begin
                    n_health = HL_STALE;
                end else begin
                    n_health = HL_LIVE;
                end
            end
            OP_CLEAR: begin
                n_status = RS_RECORDED;
                n_act    = ACT_CLEAR;
            end
            default: begin
                n_status = RS_INVALID;
            end
        endcase
    end

    // Hold the decision until commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_status <= n_status;
            r_health <= n_health;
            r_act    <= n_act;
        end
    end

    // Lease registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lease_epoch <= '0;
            r_lease_owner <= '0;
            r_identity    <= '0;
            r_last_beat   <= '0;
        end else if (i_cmd.commit) begin
            unique case (r_act)
                ACT_TAKE: begin
                    r_lease_epoch <= r_ep;
                    r_lease_owner <= r_own;
                    r_identity    <= w_guard;
                    r_last_beat   <= r_now;
                end
                ACT_BEAT_NOW: begin
                    r_last_beat <= r_now;
                end
                ACT_BEAT_ZERO: begin
                    r_last_beat <= '0;
                end
                ACT_CLEAR: begin
                    r_lease_epoch <= '0;
                    r_lease_owner <= '0;
                    r_identity    <= '0;
                    r_last_beat   <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_sts.hash_done = w_done;
    assign o_sts.take      = (n_act == ACT_TAKE);

    assign o_status        = r_status;
    assign o_health        = r_health;
    assign o_owner_out     = r_lease_owner;
    assign o_epoch_out     = r_lease_epoch;
    assign o_heartbeat_out = r_last_beat;

endmodule

// ===== src/elfu_ctrl.sv =====
// Lease controller: sequences capture, guard hashes, decision and commit.
`timescale 1ns / 1ps
module elfu_ctrl
    import elfu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    // Check guard of the stored lease while the request settles
                    o_cmd.capture    = 1'b1;
                    o_cmd.hash_start = 1'b1;
                    n_state          = S_WAIT_CHK;
                end
            end
            S_WAIT_CHK: begin
                if (i_sts.hash_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_sts.take) begin
                    o_cmd.hash_start   = 1'b1;
                    o_cmd.hash_sel_new = 1'b1;
                    n_state            = S_WAIT_NEW;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_WAIT_NEW: begin
                if (i_sts.hash_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/sv/tb_epoch_lease_fencing_unit.sv =====
// Self-checking testbench for the epoch lease fencing unit.
`timescale 1ns / 1ps
module tb_epoch_lease_fencing_unit
    import elfu_pkg::*;
();

    // One expected response: status, health and the lease left behind
    typedef struct packed {
        t_status     status;
        t_health     health;
        logic [63:0] owner;
        logic [63:0] epoch;
        logic [63:0] beat;
    } t_lease_rsp;

    // Lease predictor with the queue of responses still owed by the block
    class t_lease_scoreboard;
        logic [63:0] timeout_q;
        logic [63:0] epoch_q;
        logic [63:0] owner_q;
        logic [63:0] guard_q;
        logic [63:0] beat_q;
        t_lease_rsp  due_rsp[$];
        int          n_err;
        int          n_sent;
        int          n_seen;

        function new();
            timeout_q = TIMEOUT_RESET;
            epoch_q   = '0;
            owner_q   = '0;
            guard_q   = '0;
            beat_q    = '0;
            n_err     = 0;
            n_sent    = 0;
            n_seen    = 0;
        endfunction

        task report(input string msg);
            if (n_err < 40)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            n_err++;
        endtask

        // Owner and epoch folded into a nonzero 64-bit guard word
        function logic [63:0] guard_of(input logic [63:0] owner, input logic [63:0] epoch);
            logic [63:0] v;
            v = owner ^ ((epoch << MIX_ROT) | (epoch >> (64 - MIX_ROT))) ^ MIX_SEED;
            v = v ^ (v >> MIX_SH1);
            v = v * MIX_MUL1;
            v = v ^ (v >> MIX_SH2);
            v = v * MIX_MUL2;
            v = v ^ (v >> MIX_SH3);
            return (v == '0) ? 64'd1 : v;
        endfunction

        function bit lapsed(input logic [63:0] now);
            return beat_q == '0 || now < beat_q || now - beat_q > timeout_q;
        endfunction

        function bit guard_bad();
            return guard_q != guard_of(owner_q, epoch_q);
        endfunction

        function void take(input logic [63:0] owner, input logic [63:0] epoch,
                           input logic [63:0] now);
            epoch_q = epoch;
            owner_q = owner;
            guard_q = guard_of(owner, epoch);
            beat_q  = now;
        endfunction

        function t_status claim(input logic [63:0] owner, input logic [63:0] epoch,
                                input logic [63:0] now);
            if (owner == '0 || epoch == '0 || now == '0 || timeout_q == '0)
                return RS_INVALID;
            if (epoch_q == '0) begin
                take(owner, epoch, now);
                return RS_ACQUIRED;
            end
            if (owner_q == '0 || guard_bad())
                return RS_CORRUPT;
            if (epoch_q == epoch) begin
                if (owner_q != owner)
                    return RS_SPLIT;
                if (now < beat_q)
                    return RS_CORRUPT;
                beat_q = now;
                return RS_RENEWED;
            end
            if (!lapsed(now))
                return RS_SPLIT;
            if (epoch <= epoch_q)
                return RS_OLD_EPOCH;
            take(owner, epoch, now);
            return RS_TAKEOVER;
        endfunction

        function t_status beat(input logic [63:0] owner, input logic [63:0] epoch,
                               input logic [63:0] now);
            if (owner == '0 || epoch == '0 || now == '0)
                return RS_INVALID;
            if (epoch_q != epoch || owner_q != owner)
                return RS_LOST;
            if (guard_bad())
                return RS_CORRUPT;
            if (now < beat_q)
                return RS_TIME_BACK;
            beat_q = now;
            return RS_RECORDED;
        endfunction

        function t_status stop(input logic [63:0] owner, input logic [63:0] epoch);
            if (epoch_q != epoch || owner_q != owner)
                return RS_LOST;
            if (guard_bad())
                return RS_CORRUPT;
            beat_q = '0;
            return RS_RECORDED;
        endfunction

        function t_health peek(input logic [63:0] now);
            if (epoch_q == '0 && owner_q == '0 && beat_q == '0 && guard_q == '0)
                return HL_EMPTY;
            if (epoch_q == '0 || owner_q == '0 || guard_bad() || now == '0 ||
                timeout_q == '0)
                return HL_CORRUPT;
            return lapsed(now) ? HL_STALE : HL_LIVE;
        endfunction

        // Apply one accepted request and queue the response it owes
        function void note_request(input logic [2:0] op, input logic [63:0] owner,
                                   input logic [63:0] epoch, input logic [63:0] now);
            t_lease_rsp r;
            r.status = RS_INVALID;
            r.health = HL_EMPTY;
            case (op)
                OP_CLAIM: r.status = claim(owner, epoch, now);
                OP_BEAT:  r.status = beat(owner, epoch, now);
                OP_STOP:  r.status = stop(owner, epoch);
                OP_PEEK:  r.health = peek(now);
                OP_CLEAR: begin
                    epoch_q  = '0;
                    owner_q  = '0;
                    guard_q  = '0;
                    beat_q   = '0;
                    r.status = RS_RECORDED;
                end
                default: ;
            endcase
            r.owner = owner_q;
            r.epoch = epoch_q;
            r.beat  = beat_q;
            due_rsp.push_back(r);
            n_sent++;
        endfunction

        // Compare one response transfer against the oldest expectation
        task check_response(input logic [3:0] status, input logic [1:0] health,
                            input logic [63:0] owner, input logic [63:0] epoch,
                            input logic [63:0] beat);
            t_lease_rsp r;
            n_seen++;
            if (due_rsp.size() == 0) begin
                report($sformatf("response %0d with no request outstanding", n_seen));
                return;
            end
            r = due_rsp.pop_front();
            if (status !== r.status)
                report($sformatf("rsp %0d status %0d, want %0d", n_seen, status, r.status));
            if (health !== r.health)
                report($sformatf("rsp %0d health %0d, want %0d", n_seen, health, r.health));
            if (owner !== r.owner)
                report($sformatf("rsp %0d owner %h, want %h", n_seen, owner, r.owner));
            if (epoch !== r.epoch)
                report($sformatf("rsp %0d epoch %h, want %h", n_seen, epoch, r.epoch));
            if (beat !== r.beat)
                report($sformatf("rsp %0d heartbeat %h, want %h", n_seen, beat, r.beat));
        endtask

        function int pending();
            return due_rsp.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [63:0] i_cfg_wr_data;

    elfu_req_if req_if ();
    elfu_rsp_if rsp_if ();

    epoch_lease_fencing_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_if),
        .o_rsp         (rsp_if)
    );

    t_lease_scoreboard sb;
    int unsigned       src_idle_pct;
    int unsigned       rcv_stall_pct;
    logic [63:0]       clock_ns;
    logic [63:0]       owner_pool [4];

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Check response transfers and pick the next cycle's ready
    always @(posedge i_clk) begin
        if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            sb.check_response(rsp_if.status, rsp_if.health, rsp_if.owner_out,
                              rsp_if.epoch_out, rsp_if.heartbeat_out);
        rsp_if.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    // Hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("Run timed out at %0t with %0d responses outstanding",
                 $realtime, sb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

    // Present one request, hold it until the transfer, then note it
    task send_req(input logic [2:0] op, input logic [63:0] owner,
                  input logic [63:0] epoch, input logic [63:0] now);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        req_if.valid    <= 1'b1;
        req_if.opcode   <= op;
        req_if.owner_id <= owner;
        req_if.epoch_in <= epoch;
        req_if.now_time <= now;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        sb.note_request(op, owner, epoch, now);
    endtask

    // Drop valid and drain every outstanding response
    task drain();
        req_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task write_timeout(input logic [63:0] value);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.timeout_q = value;
    endtask

    function logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Advance the local time: mostly small steps, some at and past the timeout,
    // some large jumps forward, some backward or to anywhere, and some zero times
    task next_time(output logic [63:0] now);
        int unsigned pick;
        int unsigned cap;
        pick = $urandom_range(0, 19);
        cap  = (sb.timeout_q < 64'd16) ? 32'(sb.timeout_q) : 32'd16;
        if (pick < 11)
            clock_ns = clock_ns + $urandom_range(0, cap);
        else if (pick < 13)
            clock_ns = clock_ns + sb.timeout_q;
        else if (pick < 15)
            clock_ns = clock_ns + sb.timeout_q + 64'd1;
        else if (pick < 17)
            clock_ns = clock_ns + {32'd0, $urandom};
        else if (pick == 17)
            clock_ns = clock_ns - $urandom_range(1, 16);
        else if (pick == 18)
            clock_ns = rand64();
        now = (pick == 19) ? 64'd0 : clock_ns;
    endtask

    // Requests shaped around the current lease, with some noise mixed in
    task run_random(input int count);
        int unsigned pick;
        logic [2:0]  op;
        logic [63:0] owner;
        logic [63:0] epoch;
        logic [63:0] now;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick >= 88) begin
                op = 3'($urandom_range(0, 7));
                send_req(op, rand64(), rand64(), rand64());
                continue;
            end
            if (pick < 35)      op = OP_CLAIM;
            else if (pick < 60) op = OP_BEAT;
            else if (pick < 68) op = OP_STOP;
            else if (pick < 84) op = OP_PEEK;
            else                op = OP_CLEAR;

            pick = $urandom_range(0, 19);
            if (pick < 12)
                owner = (sb.owner_q != '0) ? sb.owner_q : owner_pool[$urandom_range(0, 3)];
            else if (pick < 16)
                owner = owner_pool[$urandom_range(0, 3)];
            else if (pick == 16)
                owner = '0;
            else
                owner = rand64();

            pick = $urandom_range(0, 19);
            if (pick < 9)
                epoch = (sb.epoch_q != '0) ? sb.epoch_q : 64'd1;
            else if (pick < 13)
                epoch = sb.epoch_q + $urandom_range(1, 3);
            else if (pick < 15)
                epoch = sb.epoch_q - 64'd1;
            else if (pick == 15)
                epoch = '0;
            else if (pick < 18)
                epoch = rand64();
            else if (pick == 18)
                epoch = '1;
            else
                epoch = 64'd1;

            next_time(now);
            send_req(op, owner, epoch, now);
        end
    endtask

    initial begin
        int wait_cycles;
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_cfg_wr_en      = 1'b0;
        i_cfg_wr_data    = '0;
        req_if.valid     = 1'b0;
        req_if.opcode    = '0;
        req_if.owner_id  = '0;
        req_if.epoch_in  = '0;
        req_if.now_time  = '0;
        rsp_if.ready     = 1'b0;
        src_idle_pct     = 0;
        rcv_stall_pct    = 0;
        clock_ns         = 64'd100;
        owner_pool[0]    = 64'd1;
        owner_pool[1]    = '1;
        owner_pool[2]    = rand64();
        owner_pool[3]    = rand64();
        sb = new();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: timeout at its reset value
        send_req(OP_PEEK,  64'd7, 64'd7, 64'd5);                    // empty lease
        send_req(OP_CLAIM, '0,    64'd5, 64'd1000);                 // zero owner
        send_req(OP_CLAIM, '1,    '0,    64'd1000);                 // zero epoch
        send_req(OP_CLAIM, '1,    64'd5, '0);                       // zero time
        send_req(OP_CLAIM, '1,    64'd5, 64'd1000);                 // acquire
        send_req(OP_CLAIM, '1,    64'd5, 64'd2000);                 // renew
        send_req(OP_CLAIM, 64'd1, 64'd5, 64'd2100);                 // same epoch, other owner
        send_req(OP_CLAIM, '1,    64'd5, 64'd1500);                 // renewal going back in time
        send_req(OP_BEAT,  '1,    64'd5, 64'd3000);
        send_req(OP_BEAT,  '1,    64'd5, 64'd2500);                 // time regression
        send_req(OP_BEAT,  64'd1, 64'd5, 64'd3000);                 // not the holder
        send_req(OP_PEEK,  '0,    '0,    64'd1_000_003_000);        // exactly at the timeout
        send_req(OP_PEEK,  '0,    '0,    64'd1_000_003_001);        // just past it
        send_req(OP_PEEK,  '0,    '0,    '0);                       // zero time
        send_req(OP_CLAIM, 64'd1, 64'd4, 64'd2_000_000_000);        // stale, lower epoch
        send_req(OP_CLAIM, 64'd1, 64'd6, 64'd2_000_000_000);        // stale takeover
        send_req(OP_STOP,  '1,    64'd5, 64'd1);                    // stop by old holder
        send_req(OP_STOP,  64'd1, 64'd6, '0);
        send_req(OP_PEEK,  '0,    '0,    64'd1);                    // stopped lease
        send_req(OP_CLAIM, '1,    '1,    '1);                       // takeover at the extremes

        // Directed: zero timeout
        write_timeout('0);
        send_req(OP_CLAIM, '1,    '1,    '1);
        send_req(OP_PEEK,  '0,    '0,    64'd5);
        send_req(OP_BEAT,  '1,    '1,    '1);
        send_req(OP_CLEAR, rand64(), rand64(), rand64());
        send_req(OP_STOP,  '0,    '0,    64'd9);                    // stop on an empty lease
        send_req(3'd5, rand64(), rand64(), rand64());
        send_req(3'd6, rand64(), rand64(), rand64());
        send_req(3'd7, '1, '1, '1);

        // Random phases: timeout and idle mix change between them
        write_timeout(64'd1000);
        run_random(170);

        write_timeout('1);
        src_idle_pct = 74;
        run_random(170);

        write_timeout(64'd1);
        src_idle_pct  = 0;
        rcv_stall_pct = 74;
        run_random(170);

        write_timeout(64'($urandom_range(2, 65535)));
        src_idle_pct  = 23;
        rcv_stall_pct = 23;
        run_random(170);

        // Drain and settle
        req_if.valid <= 1'b0;
        wait_cycles = 0;
        while (sb.pending() != 0 && wait_cycles < 50000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (32) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d responses never seen", sb.pending()));

        $display("Sent %0d requests and checked %0d responses across timeouts of zero,",
                 sb.n_sent, sb.n_seen);
        $display("one, 1000, reset value, maximum and random, under four idle and stall mixes");
        if (sb.n_err == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", sb.n_err);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/elfu_pkg.sv
src/elfu_if.sv
src/elfu_mix.sv
src/elfu_datapath.sv
src/elfu_ctrl.sv
src/epoch_lease_fencing_unit.sv
tb/sv/tb_epoch_lease_fencing_unit.sv
